// File: rtl/core/boxcar_snr_threshold_detector_unit_assert.svh
// Assertion macros for the boxcar S/N threshold detector.
// Included by the top level; depends on nothing else.
`ifndef BOXCAR_SNR_THRESHOLD_DETECTOR_UNIT_ASSERT_SVH
`define BOXCAR_SNR_THRESHOLD_DETECTOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BSD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/bsd_pkg.sv
// Shared constants, types and the coefficient table of the boxcar detector.
// Used by the search unit and the top level; depends on nothing.
package bsd_pkg;

    localparam int PIXELS      = 4096;
    localparam int WINDOWS     = 16;
    localparam int SAMPLE_BITS = 16;

    localparam int PIX_BITS   = 12;
    localparam int DM_BITS    = 8;
    localparam int TIME_BITS  = 16;
    localparam int SN_BITS    = 33;
    localparam int WIDTH_BITS = 5;

    localparam int ROW_BITS  = $clog2(PIXELS);
    localparam int IDX_BITS  = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
    localparam int SUM_BITS  = SAMPLE_BITS + IDX_BITS + 1;
    localparam int COEF_BITS = 17;
    localparam int PROD_BITS = SUM_BITS + COEF_BITS + 1;
    localparam int ROW_WIDTH = WINDOWS * SAMPLE_BITS;

    localparam logic [SN_BITS-1:0] SN_MAX       = {SN_BITS{1'b1}};
    localparam logic [SN_BITS-1:0] THRESH_RESET = SN_BITS'(393216);

    typedef logic [WINDOWS-1:0][SAMPLE_BITS-1:0] t_row;
    typedef logic [WINDOWS-1:0][COEF_BITS-1:0]   t_coef_vec;

    typedef struct packed {
        logic                   done;
        logic [PROD_BITS-2:0]   sn;
        logic [WIDTH_BITS-1:0]  width;
    } t_srch_res;

    // Entry k-1 is round(65536/sqrt(k)): the largest n with k*(2n-1)^2 <= 2^34.
    function automatic t_coef_vec coef_table();
        t_coef_vec       tab;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned odd;
        longint unsigned lim;
        lim = 64'd1 << 34;
        for (int k = 1; k <= WINDOWS; k++) begin
            lo = 64'd1;
            hi = 64'd65536;
            for (int i = 0; i < 20; i++) begin
                if (lo < hi) begin
                    mid = (lo + hi + 64'd1) >> 1;
                    odd = 64'd2 * mid - 64'd1;
                    if (longint'(k) * odd * odd <= lim) begin
                        lo = mid;
                    end else begin
                        hi = mid - 64'd1;
                    end
                end
            end
            tab[k-1] = COEF_BITS'(lo);
        end
        return tab;
    endfunction

    localparam t_coef_vec COEF = coef_table();

endpackage

// File: rtl/core/boxcar_snr_threshold_detector_unit.sv
// Top level of the boxcar S/N threshold detector: sequencer, history RAM,
// search unit, threshold register and output register. Depends on bsd_pkg,
// bsd_hist_ram, bsd_search and the assertion macro header.
//
// Channel   Direction  Handshake               Payload
// in        sink       i_in_valid/o_in_stall   pixel_index, sample, dm_index, time_index
// out       source     o_out_valid/i_out_stall cand_pixel, cand_width, cand_sn, cand_dm, cand_time
// cfg       sink       i_cfg_valid/o_cfg_ready snr_threshold (33 bits)
//
// Each item takes one RAM read, one write-back, and a serial pass over the
// window through one multiplier with a two-stage drain.
// After reset a clearing pass writes zeros to all PIXELS rows, one per cycle,
// while the input stalls; configuration writes are taken always.
// A finished candidate waits in the output register while the next item runs.
`include "boxcar_snr_threshold_detector_unit_assert.svh"

module boxcar_snr_threshold_detector_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [bsd_pkg::PIX_BITS-1:0]        i_pixel_index,
    input  logic signed [bsd_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic [bsd_pkg::DM_BITS-1:0]         i_dm_index,
    input  logic [bsd_pkg::TIME_BITS-1:0]       i_time_index,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [bsd_pkg::PIX_BITS-1:0]        o_cand_pixel,
    output logic [bsd_pkg::WIDTH_BITS-1:0]      o_cand_width,
    output logic [bsd_pkg::SN_BITS-1:0]         o_cand_sn,
    output logic [bsd_pkg::DM_BITS-1:0]         o_cand_dm,
    output logic [bsd_pkg::TIME_BITS-1:0]       o_cand_time,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bsd_pkg::SN_BITS-1:0]         i_cfg_data
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_SRCH  = 3'd3;
    localparam logic [2:0] ST_HOLD  = 3'd4;

    logic [2:0]                       r_state;
    logic [2:0]                       n_state;
    logic [bsd_pkg::ROW_BITS-1:0]     r_clr_addr;
    logic [bsd_pkg::SN_BITS-1:0]      r_thresh;
    logic [bsd_pkg::PIX_BITS-1:0]     r_pixel;
    logic [bsd_pkg::SAMPLE_BITS-1:0]  r_sample;
    logic [bsd_pkg::DM_BITS-1:0]      r_dm;
    logic [bsd_pkg::TIME_BITS-1:0]    r_time;
    logic                             r_out_valid;
    logic [bsd_pkg::PIX_BITS-1:0]     r_out_pixel;
    logic [bsd_pkg::WIDTH_BITS-1:0]   r_out_width;
    logic [bsd_pkg::SN_BITS-1:0]      r_out_sn;
    logic [bsd_pkg::DM_BITS-1:0]      r_out_dm;
    logic [bsd_pkg::TIME_BITS-1:0]    r_out_time;

    logic                             w_in_acc;
    logic                             w_we;
    logic [bsd_pkg::ROW_BITS-1:0]     w_waddr;
    logic [bsd_pkg::ROW_WIDTH-1:0]    w_wdata;
    logic [bsd_pkg::ROW_WIDTH-1:0]    w_rdata;
    bsd_pkg::t_row                    w_old_row;
    bsd_pkg::t_row                    w_new_row;
    bsd_pkg::t_srch_res               w_res;
    logic                             w_start;
    logic                             w_fin;
    logic                             w_slot;
    logic [bsd_pkg::SN_BITS-1:0]      w_sn_sat;
    logic                             w_pass;
    logic                             w_load;

    assign w_in_acc    = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    assign w_old_row = bsd_pkg::t_row'(w_rdata);

    always_comb begin
        for (int i = bsd_pkg::WINDOWS - 1; i > 0; i--) begin
            w_new_row[i] = w_old_row[i-1];
        end
        w_new_row[0] = r_sample;
    end

    assign w_start = (r_state == ST_READ);
    assign w_we    = (r_state == ST_CLEAR) || w_start;
    assign w_waddr = (r_state == ST_CLEAR) ? r_clr_addr : r_pixel[bsd_pkg::ROW_BITS-1:0];
    assign w_wdata = (r_state == ST_CLEAR) ? '0 : bsd_pkg::ROW_WIDTH'(w_new_row);

    bsd_hist_ram #(
        .DEPTH (bsd_pkg::PIXELS),
        .WIDTH (bsd_pkg::ROW_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_in_acc),
        .i_raddr (i_pixel_index[bsd_pkg::ROW_BITS-1:0]),
        .o_rdata (w_rdata)
    );

    bsd_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_row   (w_new_row),
        .o_res   (w_res)
    );

    assign w_sn_sat = (|w_res.sn[bsd_pkg::PROD_BITS-2:bsd_pkg::SN_BITS]) ?
                      bsd_pkg::SN_MAX : w_res.sn[bsd_pkg::SN_BITS-1:0];
    assign w_pass = (w_sn_sat >= r_thresh);
    assign w_fin  = ((r_state == ST_SRCH) && w_res.done) || (r_state == ST_HOLD);
    assign w_slot = !r_out_valid || !i_out_stall;
    assign w_load = w_fin && w_pass && w_slot;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == bsd_pkg::ROW_BITS'(bsd_pkg::PIXELS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_SRCH;
            end
            ST_SRCH, ST_HOLD: begin
                if (w_fin) begin
                    n_state = (w_slot || !w_pass) ? ST_IDLE : ST_HOLD;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_thresh    <= bsd_pkg::THRESH_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= bsd_pkg::ROW_BITS'(r_clr_addr + 1'b1);
            end
            if (i_cfg_valid) begin
                r_thresh <= i_cfg_data;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_pixel  <= i_pixel_index;
            r_sample <= i_sample;
            r_dm     <= i_dm_index;
            r_time   <= i_time_index;
        end
        if (w_load) begin
            r_out_pixel <= r_pixel;
            r_out_width <= w_res.width;
            r_out_sn    <= w_sn_sat;
            r_out_dm    <= r_dm;
            r_out_time  <= r_time;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cand_pixel = r_out_pixel;
    assign o_cand_width = r_out_width;
    assign o_cand_sn    = r_out_sn;
    assign o_cand_dm    = r_out_dm;
    assign o_cand_time  = r_out_time;

    `BSD_ASSERT_NOW(a_done_in_search, i_clk, i_rst_n, w_res.done && (r_state != ST_READ), (r_state == ST_SRCH || r_state == ST_HOLD || r_state == ST_IDLE), "search result outside a search")
    `BSD_ASSERT_NEXT(a_load_passes, i_clk, i_rst_n, w_load, o_out_valid && (o_cand_sn >= r_thresh), "candidate loaded below threshold")
    `BSD_ASSERT_NOW(a_clear_stalls, i_clk, i_rst_n, r_state == ST_CLEAR, o_in_stall && !w_res.done, "item taken during clearing pass")

endmodule

// File: rtl/core/bsd_hist_ram.sv
// Generic single-port-write, single-port-read synchronous RAM for the history.
// Read data is registered; depends on nothing.
module bsd_hist_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/bsd_search.sv
// Serial boxcar search: one window element per cycle through one multiplier.
// Depends on bsd_pkg for widths, the row type and the coefficient table.
module bsd_search (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  bsd_pkg::t_row      i_row,
    output bsd_pkg::t_srch_res o_res
);

    logic                                 r_issue;
    logic                                 r_s1_vld;
    logic                                 r_s2_vld;
    logic                                 r_done;
    logic [bsd_pkg::IDX_BITS-1:0]         r_cnt;
    bsd_pkg::t_row                        r_shift;
    bsd_pkg::t_row                        n_shift;
    logic signed [bsd_pkg::SUM_BITS-1:0]  r_sum;
    logic signed [bsd_pkg::SUM_BITS-1:0]  w_elem;
    logic [bsd_pkg::IDX_BITS-1:0]         r_s1_w;
    logic                                 r_s1_last;
    logic signed [bsd_pkg::PROD_BITS-1:0] r_prod;
    logic signed [bsd_pkg::PROD_BITS-1:0] w_prod;
    logic [bsd_pkg::IDX_BITS-1:0]         r_s2_w;
    logic                                 r_s2_last;
    logic [bsd_pkg::PROD_BITS-2:0]        r_best_sn;
    logic [bsd_pkg::WIDTH_BITS-1:0]       r_best_w;
    logic                                 w_better;
    logic                                 w_last;

    assign w_elem = {{(bsd_pkg::SUM_BITS - bsd_pkg::SAMPLE_BITS){r_shift[0][bsd_pkg::SAMPLE_BITS-1]}},
                     r_shift[0]};
    assign w_last = (r_cnt == bsd_pkg::IDX_BITS'(bsd_pkg::WINDOWS - 1));
    assign w_prod = bsd_pkg::PROD_BITS'(r_sum * $signed({1'b0, bsd_pkg::COEF[r_s1_w]}));
    assign w_better = !r_prod[bsd_pkg::PROD_BITS-1] &&
                      (r_prod[bsd_pkg::PROD_BITS-2:0] > r_best_sn);

    always_comb begin
        for (int i = 0; i < bsd_pkg::WINDOWS - 1; i++) begin
            n_shift[i] = r_shift[i+1];
        end
        n_shift[bsd_pkg::WINDOWS-1] = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue  <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            if (i_start) begin
                r_issue <= 1'b1;
                r_done  <= 1'b0;
            end else if (r_issue && w_last) begin
                r_issue <= 1'b0;
            end
            r_s1_vld <= r_issue && !i_start;
            r_s2_vld <= r_s1_vld && !i_start;
            if (r_s2_vld && r_s2_last && !i_start) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt     <= '0;
            r_sum     <= '0;
            r_shift   <= i_row;
            r_best_sn <= '0;
            r_best_w  <= '0;
        end else begin
            if (r_issue) begin
                r_sum     <= r_sum + w_elem;
                r_shift   <= n_shift;
                r_s1_w    <= r_cnt;
                r_s1_last <= w_last;
                r_cnt     <= bsd_pkg::IDX_BITS'(r_cnt + 1'b1);
            end
            if (r_s1_vld) begin
                r_prod    <= w_prod;
                r_s2_w    <= r_s1_w;
                r_s2_last <= r_s1_last;
            end
            if (r_s2_vld && w_better) begin
                r_best_sn <= r_prod[bsd_pkg::PROD_BITS-2:0];
                r_best_w  <= bsd_pkg::WIDTH_BITS'(r_s2_w) + bsd_pkg::WIDTH_BITS'(1);
            end
        end
    end

    assign o_res.done  = r_done;
    assign o_res.sn    = r_best_sn;
    assign o_res.width = r_best_w;

endmodule
